>>> rtl/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants for the rank/select multiset
// Store size, value width, request and status codes, and cell control.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int REQ_W      = 2;
    localparam int RANK_W     = 9;
    localparam int STAT_W     = 2;

    // stream word layouts, lowest field first, padded to whole bytes
    localparam int IN_BITS  = REQ_W + VALUE_BITS + RANK_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STAT_W + VALUE_BITS + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_ERASE  = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_ABSENT = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic cap;   // latch compare flags against the incoming key
        logic ins;   // shift right and drop the key in
        logic del;   // shift left over the first equal entry
    } t_cell_ctl;

endpackage

>>> rtl/rsm_cell.sv
// ----------------------------------------------------------------------------
// rsm_cell: one slot of the sorted store
// Holds a value and a valid bit, compares against the key and moves its
// contents to or from a neighbour on insert and erase.
// ----------------------------------------------------------------------------
module rsm_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rsm_pkg::t_cell_ctl                   i_ctl,
    input  logic signed [rsm_pkg::VALUE_BITS-1:0] i_key,
    input  logic signed [rsm_pkg::VALUE_BITS-1:0] i_ins_key,
    input  logic                                 i_left_le,
    input  logic signed [rsm_pkg::VALUE_BITS-1:0] i_left_val,
    input  logic                                 i_left_vld,
    input  logic signed [rsm_pkg::VALUE_BITS-1:0] i_right_val,
    input  logic                                 i_right_vld,
    output logic signed [rsm_pkg::VALUE_BITS-1:0] o_val,
    output logic                                 o_vld,
    output logic                                 o_le,
    output logic                                 o_eq
);

    logic signed [rsm_pkg::VALUE_BITS-1:0] r_val;
    logic                                  r_vld;
    logic                                  r_le;
    logic                                  r_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ins && !r_le) begin
            r_vld <= i_left_le ? 1'b1 : i_left_vld;
        end else if (i_ctl.del && !r_lt) begin
            r_vld <= i_right_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_le) begin
            // first slot above the key takes it, the rest move up one
            r_val <= i_left_le ? i_ins_key : i_left_val;
        end else if (i_ctl.del && !r_lt) begin
            r_val <= i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_le <= r_vld && (r_val <= i_key);
            r_lt <= r_vld && (r_val <  i_key);
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;
    assign o_le  = r_le;
    assign o_eq  = r_le && !r_lt;

endmodule

>>> rtl/rank_select_multiset.sv
// Sequence: a request accepted in S_IDLE has all cells latch their compare
// flags; in S_APPLY, once the result slot is free, the cells shift and the
// result word is registered, raising tvalid. A new request is taken only
// in S_IDLE, so the store takes no request before the last one is applied.
// Reset: synchronous, active low; empties the store and the result slot.
// ----------------------------------------------------------------------------
// rank_select_multiset: bounded sorted multiset with insert, erase, k-th query
// A row of cells keeps the values in ascending order; the top level runs
// the two-step compare/apply sequence and builds the result word.
// ----------------------------------------------------------------------------
module rank_select_multiset (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // req_type [1:0], value [33:2], rank [42:34], zero pad
    input  logic [rsm_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status [1:0], selected_value [33:2], entry_total [42:34], zero pad
    output logic [rsm_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int N = rsm_pkg::CAPACITY;
    localparam int V = rsm_pkg::VALUE_BITS;

    rsm_pkg::t_state                     r_state, n_state;
    rsm_pkg::t_req                       r_req;
    logic signed [V-1:0]                 r_key;
    logic [rsm_pkg::RANK_W-1:0]          r_rank;
    logic [rsm_pkg::CNT_W-1:0]           r_count, n_count;
    logic                                r_out_vld;
    logic [rsm_pkg::OUT_W-1:0]           r_out;
    logic [rsm_pkg::OUT_W-1:0]           n_out;

    logic                                in_acc;
    logic                                apply;
    logic                                full;
    logic                                found;
    logic                                rank_bad;
    logic signed [V-1:0]                 in_key;
    logic signed [V-1:0]                 picked;
    rsm_pkg::t_status                    status;
    rsm_pkg::t_cell_ctl                  ctl;

    logic signed [V-1:0] cell_val [N];
    logic [N-1:0]        cell_vld;
    logic [N-1:0]        cell_le;
    logic [N-1:0]        cell_eq;

    assign in_key = s_axis_tdata[rsm_pkg::REQ_W +: V];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign apply  = (r_state == rsm_pkg::S_APPLY) && (!r_out_vld || m_axis_tready);
    assign full   = (r_count == rsm_pkg::CNT_W'(N));
    assign found  = |cell_eq;
    assign rank_bad = (r_rank == '0) || (rsm_pkg::CNT_W'(r_rank) > r_count);

    always_comb begin
        ctl.cap = in_acc;
        ctl.ins = apply && (r_req == rsm_pkg::REQ_INSERT) && !full;
        ctl.del = apply && (r_req == rsm_pkg::REQ_ERASE) && found;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic                left_le;
            logic                left_vld;
            logic signed [V-1:0] left_val;
            logic                right_vld;
            logic signed [V-1:0] right_val;

            if (g == 0) begin : g_head
                assign left_le  = 1'b1;
                assign left_vld = 1'b1;
                assign left_val = r_key;
            end else begin : g_body
                assign left_le  = cell_le[g-1];
                assign left_vld = cell_vld[g-1];
                assign left_val = cell_val[g-1];
            end

            if (g == N - 1) begin : g_tail
                assign right_vld = 1'b0;
                assign right_val = r_key;
            end else begin : g_inner
                assign right_vld = cell_vld[g+1];
                assign right_val = cell_val[g+1];
            end

            rsm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_key      (in_key),
                .i_ins_key  (r_key),
                .i_left_le  (left_le),
                .i_left_val (left_val),
                .i_left_vld (left_vld),
                .i_right_val(right_val),
                .i_right_vld(right_vld),
                .o_val      (cell_val[g]),
                .o_vld      (cell_vld[g]),
                .o_le       (cell_le[g]),
                .o_eq       (cell_eq[g])
            );
        end
    endgenerate

    // k-th value: one-hot pick across the row, OR-reduced
    always_comb begin
        picked = '0;
        for (int i = 0; i < N; i++) begin
            if (r_rank == rsm_pkg::RANK_W'(i + 1)) begin
                picked = picked | cell_val[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        status  = rsm_pkg::STAT_OK;
        n_out   = '0;
        case (r_state)
            rsm_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = rsm_pkg::S_APPLY;
                end
            end
            rsm_pkg::S_APPLY: begin
                if (apply) begin
                    n_state = rsm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsm_pkg::S_IDLE;
            end
        endcase

        case (r_req)
            rsm_pkg::REQ_INSERT: begin
                if (full) begin
                    status = rsm_pkg::STAT_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            rsm_pkg::REQ_ERASE: begin
                if (!found) begin
                    status = rsm_pkg::STAT_ABSENT;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            rsm_pkg::REQ_QUERY: begin
                if (rank_bad) begin
                    status = rsm_pkg::STAT_RANGE;
                end
            end
            default: begin
                status = rsm_pkg::STAT_OK;
            end
        endcase

        n_out[rsm_pkg::STAT_W-1:0] = status;
        if (r_req == rsm_pkg::REQ_QUERY && !rank_bad) begin
            n_out[rsm_pkg::STAT_W +: V] = picked;
        end
        n_out[rsm_pkg::STAT_W + V +: rsm_pkg::CNT_W] = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsm_pkg::S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= rsm_pkg::t_req'(s_axis_tdata[rsm_pkg::REQ_W-1:0]);
            r_key  <= in_key;
            r_rank <= s_axis_tdata[rsm_pkg::REQ_W + V +: rsm_pkg::RANK_W];
        end
        if (apply) begin
            r_out <= n_out;
        end
    end

    assign s_axis_tready = (r_state == rsm_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

>>> rtl/rsm_checker.sv
// ----------------------------------------------------------------------------
// rsm_checker: port-level checks for the rank/select multiset
// Watches both stream sides and the result words over time.
// ----------------------------------------------------------------------------
module rsm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [rsm_pkg::IN_W-1:0]    s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [rsm_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int ST_LO  = 0;
    localparam int VAL_LO = rsm_pkg::STAT_W;
    localparam int CNT_LO = rsm_pkg::STAT_W + rsm_pkg::VALUE_BITS;

    logic [rsm_pkg::STAT_W-1:0] o_stat;
    logic [rsm_pkg::CNT_W-1:0]  o_cnt;

    assign o_stat = m_axis_tdata[ST_LO +: rsm_pkg::STAT_W];
    assign o_cnt  = m_axis_tdata[CNT_LO +: rsm_pkg::CNT_W];

    // one word in flight: no new word taken the cycle after one is
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (o_cnt <= rsm_pkg::CNT_W'(rsm_pkg::CAPACITY)))
        else $error("entry total above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && o_stat == rsm_pkg::STAT_FULL)
            |-> (o_cnt == rsm_pkg::CNT_W'(rsm_pkg::CAPACITY)))
        else $error("insert dropped while store not full");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && o_stat != rsm_pkg::STAT_OK)
            |-> (m_axis_tdata[VAL_LO +: rsm_pkg::VALUE_BITS] == '0))
        else $error("failed request carries a value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind rank_select_multiset rsm_checker u_rsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rank_select_multiset
// Drives insert, erase, rank and unused requests with random gaps and stalls on both
// sides. A shadow sorted queue predicts status, selected value and count for
// every request word, and the result stream is checked in order.
// ----------------------------------------------------------------------------
module testbench;

    import rsm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int MODE_FILL  = 0;
    localparam int MODE_FULL  = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct {
        t_status           status;
        logic [31:0]       sel;
        logic [CNT_W-1:0]  total;
    } t_answer;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [31:0]       value;
        logic [RANK_W-1:0] rank;
        bit                fixed;    // expected answer typed in below
        t_answer           answer;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;

    logic signed [VALUE_BITS-1:0] held_values[$];
    t_answer                      pending_results[$];
    t_row                         directed_rows[$];
    int                           error_count;
    bit                           steady;
    t_answer                      got_answer;
    t_answer                      want_answer;

    rank_select_multiset dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        error_count++;
    endtask

    // shadow of the store: ascending, new copies go after equal ones
    task automatic apply_to_shadow(input logic [REQ_W-1:0] req,
                                   input logic [31:0] value,
                                   input logic [RANK_W-1:0] rank,
                                   output t_answer ans);
        logic signed [VALUE_BITS-1:0] v;
        int pos;
        v = value;
        ans.status = STAT_OK;
        ans.sel = '0;
        case (req)
            REQ_INSERT: begin
                if (held_values.size() >= CAPACITY) begin
                    ans.status = STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_values.size() && held_values[pos] <= v) pos++;
                    held_values.insert(pos, v);
                end
            end
            REQ_ERASE: begin
                pos = 0;
                while (pos < held_values.size() && held_values[pos] != v) pos++;
                if (pos == held_values.size())
                    ans.status = STAT_ABSENT;
                else
                    held_values.delete(pos);
            end
            REQ_QUERY: begin
                if (rank == 0 || rank > held_values.size())
                    ans.status = STAT_RANGE;
                else
                    ans.sel = held_values[rank - 1];
            end
            default: ;
        endcase
        ans.total = CNT_W'(held_values.size());
    endtask

    task automatic add_row(input logic [REQ_W-1:0] req, input logic [31:0] value,
                           input logic [RANK_W-1:0] rank, input bit fixed,
                           input t_status status = STAT_OK,
                           input logic [31:0] sel = '0,
                           input logic [CNT_W-1:0] total = '0);
        t_row row;
        row.req = req;
        row.value = value;
        row.rank = rank;
        row.fixed = fixed;
        row.answer.status = status;
        row.answer.sel = sel;
        row.answer.total = total;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // one request word: optional gap, then hold valid until taken
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [31:0] value,
                                input logic [RANK_W-1:0] rank, input bit fixed,
                                input t_answer fixed_answer);
        logic [IN_W-1:0] word;
        t_answer predicted;
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        word = '0;
        word[REQ_W-1:0] = req;
        word[REQ_W +: VALUE_BITS] = value;
        word[REQ_W + VALUE_BITS +: RANK_W] = rank;
        for (int i = 0; i < gap; i++) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_to_shadow(req, value, rank, predicted);
        if (fixed)
            pending_results.insert(pending_results.size(), fixed_answer);
        else
            pending_results.insert(pending_results.size(), predicted);
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom_range(0, 6) - 3;
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic pick_request(input int mode, output logic [REQ_W-1:0] req,
                                output logic [31:0] value,
                                output logic [RANK_W-1:0] rank);
        int r;
        int cnt;
        int ins_lim;
        int era_lim;
        cnt = held_values.size();
        r = $urandom_range(0, 99);
        ins_lim = (mode == MODE_FILL) ? 85 : (mode == MODE_FULL) ? 50 : 15;
        era_lim = (mode == MODE_FILL) ? 92 : (mode == MODE_FULL) ? 55 : 80;
        value = pick_value();
        rank  = RANK_W'($urandom_range(0, CAPACITY));
        if (r < ins_lim) begin
            req = REQ_INSERT;
        end else if (r < era_lim) begin
            req = REQ_ERASE;
            // mostly erase something that is held
            if (cnt > 0 && $urandom_range(0, 3) != 0)
                value = held_values[$urandom_range(0, cnt - 1)];
        end else if (r < 97) begin
            req = REQ_QUERY;
            if (cnt > 0 && $urandom_range(0, 9) < 6) begin
                rank = RANK_W'($urandom_range(1, cnt));
            end else begin
                case ($urandom_range(0, 3))
                    0: rank = '0;
                    1: rank = RANK_W'((cnt < CAPACITY) ? cnt + 1 : CAPACITY);
                    2: rank = RANK_W'(CAPACITY);
                    default: rank = RANK_W'($urandom_range(0, CAPACITY));
                endcase
            end
        end else begin
            req = REQ_UNUSED;
        end
    endtask

    // sink: random stall before each word, then ready until one is taken
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            stall = steady ? 0 : $urandom_range(0, 3);
            for (int i = 0; i < stall; i++) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_answer.status = t_status'(m_axis_tdata[STAT_W-1:0]);
            got_answer.sel    = m_axis_tdata[STAT_W +: VALUE_BITS];
            got_answer.total  = m_axis_tdata[STAT_W + VALUE_BITS +: CNT_W];
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none pending", m_axis_tdata[31:0], '0);
            end else begin
                want_answer = pending_results.pop_front();
                if (got_answer.status != want_answer.status)
                    report_mismatch("status", 32'(got_answer.status),
                                    32'(want_answer.status));
                if (got_answer.sel != want_answer.sel)
                    report_mismatch("selected_value", got_answer.sel, want_answer.sel);
                if (got_answer.total != want_answer.total)
                    report_mismatch("entry_total", 32'(got_answer.total),
                                    32'(want_answer.total));
            end
        end
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [REQ_W-1:0]  req;
        logic [31:0]       value;
        logic [RANK_W-1:0] rank;
        t_answer           none;
        int                sent;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        steady        = 1'b0;
        none.status   = STAT_OK;
        none.sel      = '0;
        none.total    = '0;

        // empty store, bad ranks, unused request type
        add_row(REQ_QUERY,  32'h0,          9'd1,   1'b1, STAT_RANGE,  32'h0, 9'd0);
        add_row(REQ_ERASE,  32'h5,          9'd0,   1'b1, STAT_ABSENT, 32'h0, 9'd0);
        add_row(REQ_QUERY,  32'h0,          9'd0,   1'b1, STAT_RANGE,  32'h0, 9'd0);
        add_row(REQ_UNUSED, 32'h0,          9'd0,   1'b1, STAT_OK,     32'h0, 9'd0);
        // extremes and a duplicate
        add_row(REQ_INSERT, 32'h7FFF_FFFF,  9'd0,   1'b1, STAT_OK,     32'h0, 9'd1);
        add_row(REQ_INSERT, 32'h8000_0000,  9'd0,   1'b1, STAT_OK,     32'h0, 9'd2);
        add_row(REQ_INSERT, 32'h0,          9'd0,   1'b0);
        add_row(REQ_INSERT, 32'h0,          9'd0,   1'b0);
        add_row(REQ_INSERT, 32'hFFFF_FFFF,  9'd0,   1'b0);
        add_row(REQ_QUERY,  32'h0,          9'd1,   1'b1, STAT_OK, 32'h8000_0000, 9'd5);
        add_row(REQ_QUERY,  32'h0,          9'd5,   1'b1, STAT_OK, 32'h7FFF_FFFF, 9'd5);
        add_row(REQ_QUERY,  32'h0,          9'd3,   1'b0);
        add_row(REQ_QUERY,  32'hFFFF_FFFF,  9'd6,   1'b1, STAT_RANGE,  32'h0, 9'd5);
        add_row(REQ_QUERY,  32'h0,          9'd256, 1'b1, STAT_RANGE,  32'h0, 9'd5);
        add_row(REQ_ERASE,  32'h0,          9'd0,   1'b1, STAT_OK,     32'h0, 9'd4);
        add_row(REQ_ERASE,  32'h1,          9'd0,   1'b1, STAT_ABSENT, 32'h0, 9'd4);
        add_row(REQ_QUERY,  32'h0,          9'd3,   1'b0);
        add_row(REQ_UNUSED, 32'hDEAD_BEEF,  9'd511, 1'b1, STAT_OK,     32'h0, 9'd4);
        add_row(REQ_ERASE,  32'h8000_0000,  9'd256, 1'b0);
        add_row(REQ_ERASE,  32'h7FFF_FFFF,  9'd0,   1'b0);
        add_row(REQ_INSERT, 32'h5A5A_5A5A,  9'd256, 1'b0);
        add_row(REQ_QUERY,  32'hA5A5_A5A5,  9'd2,   1'b0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].value,
                         directed_rows[i].rank, directed_rows[i].fixed,
                         directed_rows[i].answer);

        // fill to capacity, sit at full for a while, then drain
        sent = 0;
        while (held_values.size() < CAPACITY && sent < 450) begin
            if (sent % 32 == 0) steady = ($urandom_range(0, 3) == 0);
            pick_request(MODE_FILL, req, value, rank);
            send_request(req, value, rank, 1'b0, none);
            sent++;
        end
        for (int i = 0; i < 30; i++) begin
            pick_request(MODE_FULL, req, value, rank);
            send_request(req, value, rank, 1'b0, none);
        end
        for (int i = 0; i < 150; i++) begin
            if (i % 32 == 0) steady = ($urandom_range(0, 3) == 0);
            pick_request(MODE_DRAIN, req, value, rank);
            send_request(req, value, rank, 1'b0, none);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rsm_pkg.sv
rtl/rsm_cell.sv
rtl/rank_select_multiset.sv
rtl/rsm_checker.sv
bench/testbench.sv
